[design/lgu_pkg.sv]
package lgu_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned DATA_WIDTH_DEF      = 16;
  localparam int unsigned LOG_TABLE_DEPTH_DEF = 256;

  // Fixed-point format of the data fields.
  localparam int unsigned FRAC = 12;

  // ln 2 in unsigned Q0.32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Loss mode codes.
  localparam logic [2:0] MODE_MSE    = 3'd0;
  localparam logic [2:0] MODE_MAE    = 3'd1;
  localparam logic [2:0] MODE_HUBER  = 3'd2;
  localparam logic [2:0] MODE_BINARY = 3'd3;
  localparam logic [2:0] MODE_CATEG  = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LOSS_MODE = 2'd0;
  localparam logic [1:0] REG_SOFTMAX   = 2'd1;
  localparam logic [1:0] REG_HUBER     = 2'd2;
  localparam logic [1:0] REG_INV_COUNT = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TERM,
    ST_TERM2,
    ST_TERM3,
    ST_NL1,
    ST_NL2,
    ST_LT1,
    ST_LT2,
    ST_LT3,
    ST_DEN,
    ST_DIV,
    ST_GHI,
    ST_GLO,
    ST_SUM,
    ST_MHI,
    ST_MLO,
    ST_MFIN,
    ST_DONE
  } lgu_state_t;

  // One entry of the log2(1 + f) table in Q0.24, found bit by bit by
  // repeated squaring. Evaluated at elaboration only.
  function automatic logic [23:0] log2_entry(input int unsigned i,
                                             input int unsigned depth_log2);
    logic [63:0] x;
    logic [23:0] r;
    x = (64'd1 << 30) + ((64'(i) << 30) >> depth_log2);
    r = '0;
    for (int k = 23; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

[design/loss_and_gradient_unit.sv]
// Channel   | Ports                                              | Direction
// ----------+----------------------------------------------------+----------
// input     | in_valid, in_stall, in_target_value,               | in
//           | in_predicted_value, in_last_element                |
// result    | out_valid, out_stall, out_gradient_value,          | out
//           | out_mean_loss, out_loss_valid                      |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,      | APB
//           | pready                                             |
//
// In the binary log loss, and in the categorical cross-entropy without the
// softmax shortcut, a restoring divider retires one quotient bit per cycle.
// All products go through one registered multiplier, one product per cycle.
// The element marked last adds the mean steps MHI, MLO and MFIN. Reset is
// synchronous and active low; it clears the sequencer, the loss sum, the
// output valid flag and the configuration registers. in_stall is high while
// an element is in work; a finished result waits in the output register while
// the next element is taken, and while that register is held by out_stall the
// next result waits in the sequencer.
module loss_and_gradient_unit #(
  parameter int unsigned DATA_WIDTH      = lgu_pkg::DATA_WIDTH_DEF,
  parameter int unsigned LOG_TABLE_DEPTH = lgu_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_target_value,
  input  logic signed [DATA_WIDTH-1:0] in_predicted_value,
  input  logic                         in_last_element,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_gradient_value,
  output logic signed [31:0]           out_mean_loss,
  output logic                         out_loss_valid,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // The table is indexed by the top mantissa bits, so the user must keep its
  // depth a power of two; the block itself does not enforce it.
  localparam int unsigned LOG_D = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned NLW   = 12 + LOG_D;

  localparam logic signed [48:0] SUM_MAX = 49'sd140737488355327;
  localparam logic [38:0]        RAW_MAX = '1;

  // Constant log2(1 + f) table.
  logic [23:0] log_tab [LOG_TABLE_DEPTH];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_tab
    assign log_tab[g] = lgu_pkg::log2_entry(g, LOG_D);
  end

  // Configuration registers.
  logic [2:0]  mode_r;
  logic        softmax_r;
  logic [14:0] delta_r;
  logic [24:0] ic_r;

  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lgu_pkg::MODE_MSE;
      softmax_r <= 1'b0;
      delta_r   <= 15'd41;
      ic_r      <= 25'h1000000;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        lgu_pkg::REG_LOSS_MODE: mode_r    <= pwdata[2:0];
        lgu_pkg::REG_SOFTMAX:   softmax_r <= pwdata[0];
        lgu_pkg::REG_HUBER:     delta_r   <= pwdata[14:0];
        lgu_pkg::REG_INV_COUNT: ic_r      <= pwdata[24:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lgu_pkg::REG_LOSS_MODE: prdata = {29'd0, mode_r};
      lgu_pkg::REG_SOFTMAX:   prdata = {31'd0, softmax_r};
      lgu_pkg::REG_HUBER:     prdata = {17'd0, delta_r};
      lgu_pkg::REG_INV_COUNT: prdata = {7'd0, ic_r};
    endcase
  end

  // Sequencer and datapath registers.
  lgu_pkg::lgu_state_t state_r, state_nxt;

  logic signed [15:0] t_r, t_nxt;
  logic signed [15:0] p_r, p_nxt;
  logic               last_r, last_nxt;
  logic signed [47:0] lt_r, lt_nxt;
  logic signed [39:0] graw_r, graw_nxt;
  logic [27:0]        lognum_r, lognum_nxt;
  logic [27:0]        nl1_r, nl1_nxt;
  logic [27:0]        nl2_r, nl2_nxt;
  logic [48:0]        acc_r, acc_nxt;
  logic signed [47:0] sum_r, sum_nxt;
  logic signed [62:0] mul_r;

  // Restoring divider: the numerator shifts out at the top while the
  // quotient bits shift in at the bottom.
  logic [51:0] dnum_r, dnum_nxt;
  logic [22:0] drem_r, drem_nxt;
  logic [22:0] dden_r, dden_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        dneg_r, dneg_nxt;

  logic signed [31:0] res_grad_r, res_grad_nxt;
  logic signed [31:0] res_mean_r, res_mean_nxt;
  logic               res_lv_r, res_lv_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_grad_r, out_grad_nxt;
  logic signed [31:0] out_mean_r, out_mean_nxt;
  logic               out_lv_r, out_lv_nxt;

  logic in_take;
  assign in_stall = (state_r != lgu_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Input saturation into the 16-bit Q3.12 range.
  logic signed [32:0] t_w, p_w;
  logic signed [15:0] t_sat, p_sat;
  assign t_w = 33'(in_target_value);
  assign p_w = 33'(in_predicted_value);

  always_comb begin
    if (t_w > 33'sd32767) begin
      t_sat = 16'sh7FFF;
    end else if (t_w < -33'sd32768) begin
      t_sat = -16'sh8000;
    end else begin
      t_sat = t_w[15:0];
    end
    if (p_w > 33'sd32767) begin
      p_sat = 16'sh7FFF;
    end else if (p_w < -33'sd32768) begin
      p_sat = -16'sh8000;
    end else begin
      p_sat = p_w[15:0];
    end
  end

  // Element terms derived from the captured pair.
  logic signed [16:0] e;
  logic [15:0]        ae;
  logic [11:0]        pc;
  logic [11:0]        qc;
  logic signed [16:0] tq;
  logic signed [16:0] pmt;
  logic [15:0]        apmt;
  logic [15:0]        at;
  logic               hsmall;

  always_comb begin
    e    = 17'(t_r) - 17'(p_r);
    ae   = e[16] ? 16'(-e) : e[15:0];
    if (p_r < 16'sd1) begin
      pc = 12'd1;
    end else if (p_r > 16'sd4095) begin
      pc = 12'd4095;
    end else begin
      pc = p_r[11:0];
    end
    qc     = 12'(13'd4096 - 13'(pc));
    tq     = 17'sd4096 - 17'(t_r);
    pmt    = $signed({5'd0, pc}) - 17'(t_r);
    apmt   = pmt[16] ? 16'(-pmt) : pmt[15:0];
    at     = t_r[15] ? 16'(-17'(t_r)) : t_r;
    hsmall = (ae <= {1'b0, delta_r});
  end

  // Table stage of -ln: leading one, mantissa index, and the log2 magnitude
  // in Q.24 that the multiplier scales by ln 2.
  logic [11:0]    nl_in;
  logic [3:0]     nl_b;
  logic [NLW-1:0] nl_idx;
  logic [27:0]    nl_m;

  always_comb begin
    nl_in = (state_r == lgu_pkg::ST_TERM) ? pc : qc;
    nl_b  = '0;
    for (int k = 0; k < 12; k++) begin
      if (nl_in[k]) begin
        nl_b = 4'(k);
      end
    end
    nl_idx = ((NLW'(nl_in) - (NLW'(1) << nl_b)) << LOG_D) >> nl_b;
    nl_m   = (28'(4'd12 - nl_b) << 24) - 28'(log_tab[nl_idx[LOG_D-1:0]]);
  end

  // Gradient and accumulator magnitudes for the split products.
  logic [38:0] gmag;
  logic [46:0] smag;
  assign gmag = graw_r[39] ? 39'(-graw_r) : graw_r[38:0];
  assign smag = sum_r[47] ? 47'(-sum_r) : sum_r[46:0];

  // Divider step.
  logic [23:0] d_rs;
  logic        d_ge;
  logic [51:0] d_q;
  assign d_rs = {drem_r, dnum_r[51]};
  assign d_ge = (d_rs >= {1'b0, dden_r});
  assign d_q  = {dnum_r[50:0], d_ge};

  // Wide sums for the final steps.
  logic [40:0]        gtot;
  logic [40:0]        mtot;
  logic signed [48:0] snew;
  logic signed [47:0] lt_acc;
  assign gtot   = acc_r[40:0] + 41'(mul_r[48:24]);
  assign mtot   = 41'((acc_r + 49'(mul_r[48:24])) >> 8);
  assign snew   = 49'(sum_r) + 49'(lt_r);
  assign lt_acc = lt_r + $signed(mul_r[47:0]);

  logic signed [32:0] mul_a;
  logic signed [29:0] mul_b;

  always_comb begin
    state_nxt    = state_r;
    t_nxt        = t_r;
    p_nxt        = p_r;
    last_nxt     = last_r;
    lt_nxt       = lt_r;
    graw_nxt     = graw_r;
    lognum_nxt   = lognum_r;
    nl1_nxt      = nl1_r;
    nl2_nxt      = nl2_r;
    acc_nxt      = acc_r;
    sum_nxt      = sum_r;
    dnum_nxt     = dnum_r;
    drem_nxt     = drem_r;
    dden_nxt     = dden_r;
    dcnt_nxt     = dcnt_r;
    dneg_nxt     = dneg_r;
    res_grad_nxt = res_grad_r;
    res_mean_nxt = res_mean_r;
    res_lv_nxt   = res_lv_r;
    out_grad_nxt = out_grad_r;
    out_mean_nxt = out_mean_r;
    out_lv_nxt   = out_lv_r;
    mul_a        = '0;
    mul_b        = '0;

    // The output register empties when its transfer completes.
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      lgu_pkg::ST_IDLE: begin
        if (in_take) begin
          t_nxt     = t_sat;
          p_nxt     = p_sat;
          last_nxt  = in_last_element;
          state_nxt = lgu_pkg::ST_TERM;
        end
      end

      lgu_pkg::ST_TERM: begin
        // First step of every mode: the simple gradients are set here.
        lt_nxt    = '0;
        graw_nxt  = '0;
        state_nxt = lgu_pkg::ST_GHI;
        case (mode_r)
          lgu_pkg::MODE_MSE: begin
            mul_a     = 33'(e);
            mul_b     = 30'(e);
            graw_nxt  = -(40'(e) <<< 13);
            state_nxt = lgu_pkg::ST_TERM2;
          end
          lgu_pkg::MODE_MAE: begin
            lt_nxt = $signed({32'd0, ae}) <<< 12;
            if (e[16]) begin
              graw_nxt = 40'sh0001000000;
            end else if (e != '0) begin
              graw_nxt = -40'sh0001000000;
            end
          end
          lgu_pkg::MODE_HUBER: begin
            state_nxt = lgu_pkg::ST_TERM2;
            if (hsmall) begin
              mul_a    = 33'(e);
              mul_b    = 30'(e);
              graw_nxt = -(40'(e) <<< 12);
            end else begin
              mul_a = $signed({18'd0, delta_r});
              mul_b = $signed({14'd0, ae});
              if (e[16]) begin
                graw_nxt = $signed({25'd0, delta_r}) <<< 12;
              end else begin
                graw_nxt = -($signed({25'd0, delta_r}) <<< 12);
              end
            end
          end
          lgu_pkg::MODE_BINARY, lgu_pkg::MODE_CATEG: begin
            lognum_nxt = nl_m;
            state_nxt  = lgu_pkg::ST_NL1;
          end
          default: begin
          end
        endcase
      end

      lgu_pkg::ST_TERM2: begin
        state_nxt = lgu_pkg::ST_GHI;
        if (mode_r == lgu_pkg::MODE_MSE) begin
          lt_nxt = $signed(mul_r[47:0]);
        end else if (hsmall) begin
          lt_nxt = $signed(mul_r[47:0]) >>> 1;
        end else begin
          lt_nxt    = $signed(mul_r[47:0]);
          mul_a     = $signed({18'd0, delta_r});
          mul_b     = $signed({15'd0, delta_r});
          state_nxt = lgu_pkg::ST_TERM3;
        end
      end

      lgu_pkg::ST_TERM3: begin
        lt_nxt    = lt_r - ($signed(mul_r[47:0]) >>> 1);
        state_nxt = lgu_pkg::ST_GHI;
      end

      lgu_pkg::ST_NL1: begin
        mul_a      = $signed({1'b0, lgu_pkg::LN2_Q32});
        mul_b      = $signed({2'd0, lognum_r});
        lognum_nxt = nl_m;
        state_nxt  = lgu_pkg::ST_NL2;
      end

      lgu_pkg::ST_NL2: begin
        nl1_nxt   = mul_r[59:32];
        mul_a     = $signed({1'b0, lgu_pkg::LN2_Q32});
        mul_b     = $signed({2'd0, lognum_r});
        state_nxt = lgu_pkg::ST_LT1;
      end

      lgu_pkg::ST_LT1: begin
        nl2_nxt   = mul_r[59:32];
        mul_a     = 33'(t_r);
        mul_b     = $signed({2'd0, nl1_r});
        state_nxt = lgu_pkg::ST_LT2;
      end

      lgu_pkg::ST_LT2: begin
        if (mode_r == lgu_pkg::MODE_BINARY) begin
          lt_nxt    = $signed(mul_r[47:0]);
          mul_a     = 33'(tq);
          mul_b     = $signed({2'd0, nl2_r});
          state_nxt = lgu_pkg::ST_LT3;
        end else begin
          lt_nxt = $signed(mul_r[47:0]) >>> 12;
          if (softmax_r) begin
            graw_nxt  = 40'(pmt) <<< 12;
            state_nxt = lgu_pkg::ST_GHI;
          end else begin
            // Quotient of -t by the clamped prediction, in Q.24.
            dnum_nxt  = 52'(at) << 24;
            dden_nxt  = 23'(pc);
            drem_nxt  = '0;
            dcnt_nxt  = 6'd51;
            dneg_nxt  = !t_r[15] && (t_r != '0);
            state_nxt = lgu_pkg::ST_DIV;
          end
        end
      end

      lgu_pkg::ST_LT3: begin
        lt_nxt    = lt_acc >>> 12;
        mul_a     = $signed({21'd0, pc});
        mul_b     = $signed({18'd0, qc});
        state_nxt = lgu_pkg::ST_DEN;
      end

      lgu_pkg::ST_DEN: begin
        dnum_nxt  = 52'(apmt) << 36;
        dden_nxt  = mul_r[22:0];
        drem_nxt  = '0;
        dcnt_nxt  = 6'd51;
        dneg_nxt  = pmt[16];
        state_nxt = lgu_pkg::ST_DIV;
      end

      lgu_pkg::ST_DIV: begin
        drem_nxt = d_ge ? 23'(d_rs - {1'b0, dden_r}) : d_rs[22:0];
        dnum_nxt = d_q;
        dcnt_nxt = dcnt_r - 6'd1;
        if (dcnt_r == '0) begin
          // Clamp the raw derivative before it takes its sign.
          if (d_q[51:39] != '0) begin
            graw_nxt = dneg_r ? -$signed({1'b0, RAW_MAX}) : $signed({1'b0, RAW_MAX});
          end else begin
            graw_nxt = dneg_r ? -$signed({1'b0, d_q[38:0]}) : $signed({1'b0, d_q[38:0]});
          end
          state_nxt = lgu_pkg::ST_GHI;
        end
      end

      lgu_pkg::ST_GHI: begin
        mul_a     = $signed({18'd0, gmag[38:24]});
        mul_b     = $signed({5'd0, ic_r});
        state_nxt = lgu_pkg::ST_GLO;
      end

      lgu_pkg::ST_GLO: begin
        acc_nxt   = mul_r[48:0];
        mul_a     = $signed({9'd0, gmag[23:0]});
        mul_b     = $signed({5'd0, ic_r});
        state_nxt = lgu_pkg::ST_SUM;
      end

      lgu_pkg::ST_SUM: begin
        if (graw_r[39]) begin
          res_grad_nxt = (gtot > 41'h80000000) ? 32'sh80000000 : 32'(-gtot);
        end else begin
          res_grad_nxt = (gtot > 41'h7FFFFFFF) ? 32'sh7FFFFFFF : gtot[31:0];
        end
        if (snew > SUM_MAX) begin
          sum_nxt = SUM_MAX[47:0];
        end else if (snew < -SUM_MAX) begin
          sum_nxt = 48'(-SUM_MAX);
        end else begin
          sum_nxt = snew[47:0];
        end
        if (last_r) begin
          state_nxt = lgu_pkg::ST_MHI;
        end else begin
          res_mean_nxt = '0;
          res_lv_nxt   = 1'b0;
          state_nxt    = lgu_pkg::ST_DONE;
        end
      end

      lgu_pkg::ST_MHI: begin
        mul_a     = $signed({10'd0, smag[46:24]});
        mul_b     = $signed({5'd0, ic_r});
        state_nxt = lgu_pkg::ST_MLO;
      end

      lgu_pkg::ST_MLO: begin
        acc_nxt   = mul_r[48:0];
        mul_a     = $signed({9'd0, smag[23:0]});
        mul_b     = $signed({5'd0, ic_r});
        state_nxt = lgu_pkg::ST_MFIN;
      end

      lgu_pkg::ST_MFIN: begin
        if (sum_r[47]) begin
          res_mean_nxt = (mtot > 41'h80000000) ? 32'sh80000000 : 32'(-mtot);
        end else begin
          res_mean_nxt = (mtot > 41'h7FFFFFFF) ? 32'sh7FFFFFFF : mtot[31:0];
        end
        res_lv_nxt = 1'b1;
        sum_nxt    = '0;
        state_nxt  = lgu_pkg::ST_DONE;
      end

      lgu_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_grad_nxt  = res_grad_r;
          out_mean_nxt  = res_mean_r;
          out_lv_nxt    = res_lv_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lgu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lgu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    p_r        <= p_nxt;
    last_r     <= last_nxt;
    lt_r       <= lt_nxt;
    graw_r     <= graw_nxt;
    lognum_r   <= lognum_nxt;
    nl1_r      <= nl1_nxt;
    nl2_r      <= nl2_nxt;
    acc_r      <= acc_nxt;
    dnum_r     <= dnum_nxt;
    drem_r     <= drem_nxt;
    dden_r     <= dden_nxt;
    dcnt_r     <= dcnt_nxt;
    dneg_r     <= dneg_nxt;
    res_grad_r <= res_grad_nxt;
    res_mean_r <= res_mean_nxt;
    res_lv_r   <= res_lv_nxt;
    out_grad_r <= out_grad_nxt;
    out_mean_r <= out_mean_nxt;
    out_lv_r   <= out_lv_nxt;
    mul_r      <= mul_a * mul_b;
  end

  assign out_valid          = out_valid_r;
  assign out_gradient_value = out_grad_r;
  assign out_mean_loss      = out_mean_r;
  assign out_loss_valid     = out_lv_r;

endmodule
